/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL. Each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define BGC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define BGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/bgc_pkg.sv */
// ----------------------------------------------------------------------------
// bgc_pkg
// Types and constants shared by the button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int STAMP_W        = 32;
  localparam int THR_W          = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int MAX_EVENTS     = 3;

  typedef enum logic [2:0] {
    EV_PRESSED     = 3'd0,
    EV_REL_SHORT   = 3'd1,
    EV_REL_MEDIUM  = 3'd2,
    EV_REL_LONG    = 3'd3,
    EV_RELEASED    = 3'd4,
    EV_DOUBLECLICK = 3'd5,
    EV_SHORT_HOLD  = 3'd6,
    EV_MEDIUM_HOLD = 3'd7
  } event_code_t;

  typedef enum logic [2:0] {
    REG_REL_SHORT    = 3'd0,
    REG_REL_LONG     = 3'd1,
    REG_HOLD_SHORT   = 3'd2,
    REG_HOLD_MEDIUM  = 3'd3,
    REG_DOUBLE_CLICK = 3'd4
  } cfg_index_t;

  localparam logic [THR_W-1:0] REL_SHORT_RST    = 16'd400;
  localparam logic [THR_W-1:0] REL_LONG_RST     = 16'd2000;
  localparam logic [THR_W-1:0] HOLD_SHORT_RST   = 16'd600;
  localparam logic [THR_W-1:0] HOLD_MEDIUM_RST  = 16'd4000;
  localparam logic [THR_W-1:0] DOUBLE_CLICK_RST = 16'd600;

  typedef struct packed {
    logic [THR_W-1:0] rel_short_ms;
    logic [THR_W-1:0] rel_long_ms;
    logic [THR_W-1:0] hold_short_ms;
    logic [THR_W-1:0] hold_medium_ms;
    logic [THR_W-1:0] double_click_ms;
  } cfg_t;

  // Events caused by one tick, in delivery order from code[0].
  typedef struct packed {
    event_code_t [MAX_EVENTS-1:0] code;
    logic [1:0]                   count;
    logic [STAMP_W-1:0]           stamp;
  } ev_bundle_t;

endpackage

/* sv/bgc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bgc_cfg_regs
// Threshold register file written through the configuration channel.
// ----------------------------------------------------------------------------
module bgc_cfg_regs
  import bgc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [THR_W-1:0]     wr_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rel_short_ms    <= REL_SHORT_RST;
      cfg.rel_long_ms     <= REL_LONG_RST;
      cfg.hold_short_ms   <= HOLD_SHORT_RST;
      cfg.hold_medium_ms  <= HOLD_MEDIUM_RST;
      cfg.double_click_ms <= DOUBLE_CLICK_RST;
    end else if (wr_en) begin
      unique case (cfg_index_t'(wr_index))
        REG_REL_SHORT:    cfg.rel_short_ms    <= wr_data;
        REG_REL_LONG:     cfg.rel_long_ms     <= wr_data;
        REG_HOLD_SHORT:   cfg.hold_short_ms   <= wr_data;
        REG_HOLD_MEDIUM:  cfg.hold_medium_ms  <= wr_data;
        REG_DOUBLE_CLICK: cfg.double_click_ms <= wr_data;
        default: ; // drop writes to unmapped indexes
      endcase
    end
  end

endmodule

/* sv/bgc_classify.sv */
// ----------------------------------------------------------------------------
// bgc_classify
// Button state and per-tick event decision.
// ----------------------------------------------------------------------------
module bgc_classify
  import bgc_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
)(
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [STAMP_W-1:0] now_ms,
  input  logic               pin_level,
  input  cfg_t               cfg,
  output ev_bundle_t         bundle
);

  logic                  is_down;
  logic                  short_hold_done;
  logic                  medium_hold_done;
  logic [TIME_WIDTH-1:0] change_time;
  logic [TIME_WIDTH-1:0] release_time;

  logic [63:0]           now_wide;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] held;
  logic [TIME_WIDTH-1:0] since_rel;
  logic [63:0]           sp_w, lp_w, hs_w, hm_w, dc_w;
  logic                  pressed;
  logic                  press_edge, release_edge, holding;
  logic                  sh_due, mh_due;

  // Zero-extend or truncate everything to the time width.
  assign now_wide  = {32'd0, now_ms};
  assign now_t     = now_wide[TIME_WIDTH-1:0];
  assign sp_w      = {48'd0, cfg.rel_short_ms};
  assign lp_w      = {48'd0, cfg.rel_long_ms};
  assign hs_w      = {48'd0, cfg.hold_short_ms};
  assign hm_w      = {48'd0, cfg.hold_medium_ms};
  assign dc_w      = {48'd0, cfg.double_click_ms};

  assign pressed      = !pin_level;
  assign held         = now_t - change_time;
  assign since_rel    = now_t - release_time;
  assign press_edge   = !is_down && pressed;
  assign release_edge = is_down && !pressed;
  assign holding      = is_down && pressed;
  assign sh_due       = holding && !short_hold_done && (held > hs_w[TIME_WIDTH-1:0]);
  assign mh_due       = holding && !medium_hold_done && (held > hm_w[TIME_WIDTH-1:0]);

  always_comb begin
    bundle.stamp = now_ms;
    bundle.count = 2'd0;
    bundle.code  = '{default: EV_PRESSED};
    priority if (press_edge) begin
      bundle.code[0] = EV_PRESSED;
      bundle.count   = 2'd1;
    end else if (release_edge) begin
      if (held < sp_w[TIME_WIDTH-1:0]) begin
        bundle.code[0] = EV_REL_SHORT;
      end else if (held < lp_w[TIME_WIDTH-1:0]) begin
        bundle.code[0] = EV_REL_MEDIUM;
      end else begin
        bundle.code[0] = EV_REL_LONG;
      end
      bundle.code[1] = EV_RELEASED;
      bundle.code[2] = EV_DOUBLECLICK;
      bundle.count   = (since_rel < dc_w[TIME_WIDTH-1:0]) ? 2'd3 : 2'd2;
    end else if (sh_due) begin
      bundle.code[0] = EV_SHORT_HOLD;
      bundle.code[1] = EV_MEDIUM_HOLD;
      bundle.count   = mh_due ? 2'd2 : 2'd1;
    end else if (mh_due) begin
      bundle.code[0] = EV_MEDIUM_HOLD;
      bundle.count   = 2'd1;
    end else begin
      bundle.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_down          <= 1'b0;
      short_hold_done  <= 1'b0;
      medium_hold_done <= 1'b0;
      change_time      <= '0;
      release_time     <= '0;
    end else if (fire) begin
      if (press_edge) begin
        is_down          <= 1'b1;
        short_hold_done  <= 1'b0;
        medium_hold_done <= 1'b0;
        change_time      <= now_t;
      end
      if (release_edge) begin
        is_down      <= 1'b0;
        change_time  <= now_t;
        release_time <= now_t;
      end
      if (sh_due) begin
        short_hold_done <= 1'b1;
      end
      if (mh_due) begin
        medium_hold_done <= 1'b1;
      end
    end
  end

endmodule

/* sv/bgc_out_stage.sv */
// ----------------------------------------------------------------------------
// bgc_out_stage
// Result register: holds one tick's events and hands them out one per beat.
// ----------------------------------------------------------------------------
module bgc_out_stage
  import bgc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  ev_bundle_t  bundle_in,
  output logic        can_load,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [2:0] event_code, [34:3] event_time, [39:35] zero
  output logic        m_tlast
);

  ev_bundle_t held_bundle;
  logic [1:0] idx;
  logic       pop;

  assign m_tvalid = (held_bundle.count != 2'd0);
  assign m_tlast  = (idx == held_bundle.count - 2'd1);
  assign m_tdata  = {5'd0, held_bundle.stamp, held_bundle.code[idx]};
  assign pop      = m_tvalid && m_tready;
  assign can_load = !m_tvalid || (pop && m_tlast);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bundle.count <= 2'd0;
      idx               <= 2'd0;
    end else if (load) begin
      held_bundle.count <= bundle_in.count;
      idx               <= 2'd0;
    end else if (pop && m_tlast) begin
      held_bundle.count <= 2'd0;
      idx               <= 2'd0;
    end else if (pop) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_bundle.code  <= bundle_in.code;
      held_bundle.stamp <= bundle_in.stamp;
    end
  end

endmodule

/* sv/button_gesture_classifier.sv */
// ----------------------------------------------------------------------------
// button_gesture_classifier
// Classifies button press, release and hold gestures from timed level samples.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one transaction per tick, s_tdata carries the millisecond
//   timestamp and the raw active-low pin level. Master stream: one transaction
//   per event, tlast marks the last event caused by a tick. A tick that
//   causes no event produces no output transaction.
//   Configuration: write the five 16-bit thresholds through cfg_valid/cfg_ready
//   only while the block is idle; cfg_ready is always high, unmapped indexes
//   are dropped.
//   Path: the input register takes a tick, then the tick is classified into the
//   result register, which presents the first event of that tick.
//   Throughput: one tick per cycle while each tick yields at most one event and
//   m_tready stays high; a tick with N events occupies the result register for
//   N output beats, since the result register drains one event per cycle while m_tready is high.
//   Reset (rst, synchronous): button taken as released, hold flags and both
//   timestamps cleared, thresholds back to their defaults, output empty.
//   Stall: when m_tready is low the result register holds its events, the
//   input register holds the next tick, and s_tready drops once both are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module button_gesture_classifier
  import bgc_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
)(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,   // [31:0] now_ms, [32] pin_level, [39:33] zero
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [39:0]          m_tdata,   // [2:0] event_code, [34:3] event_time, [39:35] zero
  output logic                 m_tlast,   // last_of_run
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data
);

  // Input register
  logic               in_valid;
  logic [STAMP_W-1:0] in_now;
  logic               in_pin;

  logic       fire;
  logic       can_load;
  cfg_t       cfg;
  ev_bundle_t bundle;

  assign cfg_ready = 1'b1;

  // Classify a tick once the result register can take its events.
  assign fire     = in_valid && can_load;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Hold payload whenever the register is not taking a new transaction.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_now <= s_tdata[31:0];
      in_pin <= s_tdata[32];
    end
  end

  bgc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bgc_classify #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_classify (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .now_ms    (in_now),
    .pin_level (in_pin),
    .cfg       (cfg),
    .bundle    (bundle)
  );

  bgc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .bundle_in (bundle),
    .can_load  (can_load),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // A run of events is never cut short before its last beat.
  `BGC_ASSERT_NEXT(a_run_continues, m_tvalid && m_tready && !m_tlast, m_tvalid, "run cut short")

  // A classified tick shows up at the output exactly when it caused events.
  `BGC_ASSERT_NEXT(a_load_visible, fire, m_tvalid == ($past(bundle.count) != 2'd0), "tick lost")

  // A press is always the only event of its tick.
  `BGC_ASSERT(a_press_alone, !(m_tvalid && (m_tdata[2:0] == EV_PRESSED)) || m_tlast, "press run")

endmodule

/* test/button_gesture_classifier_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_classifier_tb
// Self-checking bench for the press, release and hold gesture classifier.
// Ticks go in on the slave stream. A scoreboard replays each accepted tick
// through its own gesture tracker and queues the events that the tick should
// raise. Every event that leaves the master stream is checked, field by field,
// against the oldest queued event. A directed run at reset thresholds comes
// first. Random press/hold/release gestures and noise ticks follow, under
// several threshold settings. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module button_gesture_classifier_tb;
  import bgc_pkg::*;

  // Raw pin levels: the button is active low.
  localparam logic PIN_DOWN = 1'b0;
  localparam logic PIN_UP   = 1'b1;

  // Receiver hold-off that lets the block fill up and stall its input.
  localparam int HOLD_OFF_CYCLES = 120;
  // Settle time after the last event: input register plus result register.
  localparam int SETTLE_CYCLES   = 6;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the button gestures and holds the events still due
  // --------------------------------------------------------------------------
  class gesture_scoreboard;
    typedef struct {
      event_code_t        code;
      logic [STAMP_W-1:0] stamp;
      logic               last;
    } gesture_event_t;

    logic [THR_W-1:0]   rel_short, rel_long, hold_short, hold_medium, double_click;
    logic               btn_down, short_hold_seen, medium_hold_seen;
    logic [STAMP_W-1:0] change_t, release_t;
    gesture_event_t     due_q[$];
    int                 errors;
    int                 events_seen;

    function new();
      rel_short        = REL_SHORT_RST;
      rel_long         = REL_LONG_RST;
      hold_short       = HOLD_SHORT_RST;
      hold_medium      = HOLD_MEDIUM_RST;
      double_click     = DOUBLE_CLICK_RST;
      btn_down         = 1'b0;
      short_hold_seen  = 1'b0;
      medium_hold_seen = 1'b0;
      change_t         = '0;
      release_t        = '0;
      errors           = 0;
      events_seen      = 0;
    endfunction

    // Unmapped indexes change nothing.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] val);
      case (idx)
        REG_REL_SHORT:    rel_short    = val;
        REG_REL_LONG:     rel_long     = val;
        REG_HOLD_SHORT:   hold_short   = val;
        REG_HOLD_MEDIUM:  hold_medium  = val;
        REG_DOUBLE_CLICK: double_click = val;
        default: ;
      endcase
    endfunction

    // Queue the events that one accepted tick raises. Differences wrap at 32 bits.
    function void note_tick(logic [STAMP_W-1:0] now, logic level);
      logic [STAMP_W-1:0] held;
      logic [STAMP_W-1:0] since_rel;
      logic               pressed;
      event_code_t        raised[$];
      gesture_event_t     ev;
      pressed   = !level;
      held      = now - change_t;
      since_rel = now - release_t;
      if (!btn_down && pressed) begin
        short_hold_seen  = 1'b0;
        medium_hold_seen = 1'b0;
        btn_down         = 1'b1;
        change_t         = now;
        raised.push_back(EV_PRESSED);
      end else if (btn_down && !pressed) begin
        // short test first, then long: thresholds are not checked for order
        if (held < rel_short)
          raised.push_back(EV_REL_SHORT);
        else if (held < rel_long)
          raised.push_back(EV_REL_MEDIUM);
        else
          raised.push_back(EV_REL_LONG);
        raised.push_back(EV_RELEASED);
        if (since_rel < double_click)
          raised.push_back(EV_DOUBLECLICK);
        btn_down  = 1'b0;
        change_t  = now;
        release_t = now;
      end else if (btn_down) begin
        // both holds may fall due on one tick: short one first
        if (!short_hold_seen && held > hold_short) begin
          raised.push_back(EV_SHORT_HOLD);
          short_hold_seen = 1'b1;
        end
        if (!medium_hold_seen && held > hold_medium) begin
          raised.push_back(EV_MEDIUM_HOLD);
          medium_hold_seen = 1'b1;
        end
      end
      foreach (raised[i]) begin
        ev.code  = raised[i];
        ev.stamp = now;
        ev.last  = (i == raised.size() - 1);
        due_q.push_back(ev);
      end
    endfunction

    function void check_event(logic [2:0] code, logic [STAMP_W-1:0] stamp, logic last);
      gesture_event_t exp_ev;
      events_seen++;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: event with nothing due, expected none, actual code %0d time %0h last %0b",
                 $time, code, stamp, last);
        return;
      end
      exp_ev = due_q.pop_front();
      if (code !== exp_ev.code) begin
        errors++;
        $display("%0t: event_code mismatch, expected %0d, actual %0d",
                 $time, exp_ev.code, code);
      end
      if (stamp !== exp_ev.stamp) begin
        errors++;
        $display("%0t: event_time mismatch, expected %0h, actual %0h",
                 $time, exp_ev.stamp, stamp);
      end
      if (last !== exp_ev.last) begin
        errors++;
        $display("%0t: tlast mismatch, expected %0b, actual %0b",
                 $time, exp_ev.last, last);
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and bench signals
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;

  logic                 s_tvalid;
  logic                 s_tready;
  logic [39:0]          s_tdata;   // [31:0] now_ms, [32] pin_level, [39:33] zero
  logic                 m_tvalid;
  logic                 m_tready;
  logic [39:0]          m_tdata;   // [2:0] event_code, [34:3] event_time, [39:35] zero
  logic                 m_tlast;   // last_of_run
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [THR_W-1:0]     cfg_data;

  gesture_scoreboard  sb;
  logic [STAMP_W-1:0] clock_ms;       // running tick timestamp
  bit                 idle_in;        // sender inserts random gaps
  bit                 idle_out;       // receiver inserts random stalls
  bit                 hold_off_req;   // ask the receiver for one long hold-off
  int                 ticks_sent;
  int                 directed_ticks;
  int                 settings_used;

  always #5 clk = ~clk;

  button_gesture_classifier i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Monitor: sample every handshake at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready)
        sb.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready)
        sb.note_tick(s_tdata[31:0], s_tdata[32]);
      if (m_tvalid && m_tready)
        sb.check_event(m_tdata[2:0], m_tdata[34:3], m_tlast);
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall before each transaction, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        // hold off while the sender keeps offering ticks, so s_tready drops
        m_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      stall = idle_out ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks: entered and left at a falling edge
  // --------------------------------------------------------------------------
  // Offer one tick; keep tvalid high on return so back-to-back ticks need no drop.
  task automatic send_tick(logic [STAMP_W-1:0] t, logic level);
    int gap;
    gap = idle_in ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {7'b0, level, t};
    do @(posedge clk); while (!s_tready);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Drop tvalid and hold until every queued event is out, then wait out the given
  // settle time: a tick that raises nothing may still sit in the input register.
  task automatic wait_drained(int settle);
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // Write all five thresholds, then one unmapped index that must be dropped.
  task automatic configure(logic [THR_W-1:0] sp, logic [THR_W-1:0] lp,
                           logic [THR_W-1:0] hs, logic [THR_W-1:0] hm,
                           logic [THR_W-1:0] dc);
    write_reg(REG_REL_SHORT, sp);
    write_reg(REG_REL_LONG, lp);
    write_reg(REG_HOLD_SHORT, hs);
    write_reg(REG_HOLD_MEDIUM, hm);
    write_reg(REG_DOUBLE_CLICK, dc);
    write_reg(CFG_IDX_W'($urandom_range(REG_DOUBLE_CLICK + 1, (1 << CFG_IDX_W) - 1)),
              THR_W'($urandom()));
    cfg_valid = 1'b0;
    settings_used++;
  endtask

  // Time step between ticks, mostly near the current thresholds.
  function automatic logic [STAMP_W-1:0] pick_delta();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom_range(0, 40);
      2:       return sb.rel_short + $urandom_range(0, 2) - 1;
      3:       return sb.rel_long + $urandom_range(0, 2) - 1;
      4:       return sb.hold_short + $urandom_range(0, 2) - 1;
      5:       return sb.hold_medium + $urandom_range(0, 2) - 1;
      6:       return sb.double_click + $urandom_range(0, 2) - 1;
      default: return $urandom_range(0, 70000);
    endcase
  endfunction

  // Well-formed gesture: press, zero to three ticks held down, release.
  task automatic random_gesture();
    int holds;
    holds = $urandom_range(0, 3);
    clock_ms += pick_delta();
    send_tick(clock_ms, PIN_DOWN);
    repeat (holds) begin
      clock_ms += pick_delta();
      send_tick(clock_ms, PIN_DOWN);
    end
    clock_ms += pick_delta();
    send_tick(clock_ms, PIN_UP);
  endtask

  // Mostly gestures, some noise ticks with random level or time jumps,
  // and now and then a pause until every event is out.
  task automatic run_random(int n);
    int start;
    start = ticks_sent;
    while (ticks_sent - start < n) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          clock_ms = ($urandom_range(0, 3) == 0) ? $urandom() : clock_ms + pick_delta();
          send_tick(clock_ms, 1'($urandom_range(0, 1)));
        end
        2:       wait_drained(0);
        default: random_gesture();
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    idle_in        = 1'b1;
    idle_out       = 1'b1;
    hold_off_req   = 1'b0;
    ticks_sent     = 0;
    settings_used  = 1;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Directed run at reset thresholds.
    // first release after reset sits near time 0: reported as a double click
    send_tick(32'd100, PIN_DOWN);
    send_tick(32'd300, PIN_UP);
    // steady released level raises nothing
    send_tick(32'd500, PIN_UP);
    // long hold: short hold, quiet tick, medium hold, long release
    send_tick(32'd1000, PIN_DOWN);
    send_tick(32'd1601, PIN_DOWN);
    send_tick(32'd1700, PIN_DOWN);
    send_tick(32'd5001, PIN_DOWN);
    send_tick(32'd5100, PIN_UP);
    // both holds due on one tick
    send_tick(32'd6000, PIN_DOWN);
    send_tick(32'd10500, PIN_DOWN);
    send_tick(32'd10600, PIN_UP);
    // medium release, then a quick click that lands as a double click
    send_tick(32'd11000, PIN_DOWN);
    send_tick(32'd11500, PIN_UP);
    send_tick(32'd11700, PIN_DOWN);
    send_tick(32'd11800, PIN_UP);
    // press before the timestamp wraps, release after it
    send_tick(32'hFFFF_FF00, PIN_DOWN);
    send_tick(32'h0000_0100, PIN_UP);
    // timestamp extremes
    send_tick(32'hFFFF_FFFF, PIN_DOWN);
    send_tick(32'h0000_0000, PIN_UP);
    // held exactly the short threshold: medium
    send_tick(32'd20000, PIN_DOWN);
    send_tick(32'd20400, PIN_UP);
    // held exactly the hold delay: no hold yet; one past it: hold; long release
    // at exactly the long threshold
    send_tick(32'd21000, PIN_DOWN);
    send_tick(32'd21600, PIN_DOWN);
    send_tick(32'd21601, PIN_DOWN);
    send_tick(32'd23000, PIN_UP);
    directed_ticks = ticks_sent;
    wait_drained(SETTLE_CYCLES);

    // Reset thresholds, back-to-back ticks against one long receiver hold-off.
    clock_ms     = $urandom();
    idle_in      = 1'b0;
    idle_out     = 1'b1;
    hold_off_req = 1'b1;
    run_random(22);
    wait_drained(SETTLE_CYCLES);

    // All thresholds zero: every release long, holds on any elapsed time,
    // no double clicks. No idling on either side.
    configure('0, '0, '0, '0, '0);
    idle_in  = 1'b0;
    idle_out = 1'b0;
    run_random(18);
    wait_drained(SETTLE_CYCLES);

    // All thresholds at their maximum.
    configure('1, '1, '1, '1, '1);
    idle_in  = 1'b1;
    idle_out = 1'b0;
    run_random(18);
    wait_drained(SETTLE_CYCLES);

    // Random thresholds, in no particular order.
    configure(THR_W'($urandom()), THR_W'($urandom()), THR_W'($urandom_range(0, 3000)),
              THR_W'($urandom_range(0, 6000)), THR_W'($urandom_range(0, 3000)));
    idle_in  = 1'b1;
    idle_out = 1'b1;
    run_random(22);
    wait_drained(SETTLE_CYCLES);

    $display("Run covered %0d ticks (%0d directed) under %0d threshold settings",
             ticks_sent, directed_ticks, settings_used);
    $display("and checked %0d events with %0d mismatches", sb.events_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard limit, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Timeout with %0d events still due", sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/bgc_pkg.sv
sv/bgc_cfg_regs.sv
sv/bgc_classify.sv
sv/bgc_out_stage.sv
sv/button_gesture_classifier.sv
test/button_gesture_classifier_tb.sv
